FILE: src/srv_pkg.sv
// ----------------------------------------------------------------------------
// srv_pkg: shared types for the Snell refraction vector block
// Transfer payloads of the input and output channels and the fixed field
// widths of the Q2.14 vector and Q4.12 ratio formats.
// ----------------------------------------------------------------------------
package srv_pkg;

  localparam int unsigned VEC_W      = 16;  // vector component width
  localparam int unsigned RATIO_W    = 16;  // index ratio width
  localparam int unsigned RATIO_FRAC = 12;  // index ratio fraction bits

  typedef struct packed {
    logic signed [VEC_W-1:0] incident_x;
    logic signed [VEC_W-1:0] incident_y;
    logic signed [VEC_W-1:0] incident_z;
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
    logic        [RATIO_W-1:0] index_ratio;
  } srv_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    refracted_ok;
  } srv_out_t;

endpackage

FILE: src/snell_refraction_vector.sv
// ----------------------------------------------------------------------------
// snell_refraction_vector: refracted ray direction by Snell's law
// Computes cos = min(-I.N, 1), P = (I + N*cos) * ratio, q = 1 - |P|^2 and,
// when q > 0, the refracted direction P - N*sqrt(q); otherwise flags total
// internal reflection with a zero direction.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake                  Payload
//   -------  ---  -------------------------  -------------------------------
//   input    in   in_valid_i / in_ready_o    in_data_i  (srv_pkg::srv_in_t)
//   output   out  out_valid_o / out_ready_i  out_data_o (srv_pkg::srv_out_t)
//
// One transfer per cycle on each side, sustained while out_ready_i stays high.
// From input transfer to out_valid_o an item passes ten arithmetic stages
// and FRAC_BITS+1 square root stages, one root bit each, and then enters
// the output buffer.
// Reset clears the stage valid bits and the output buffer count and pointers;
// the buffer entries and the datapath registers carry no reset.
// The whole pipeline advances on one enable; it holds only when an item sits
// in the last stage and the output buffer is full. in_ready_o comes from
// registers only, so a waiting result does not block new input until then.
// ----------------------------------------------------------------------------
module snell_refraction_vector #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srv_pkg::srv_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output srv_pkg::srv_out_t out_data_o
);

  // --------------------------------------------------------------------------
  // Widths
  // --------------------------------------------------------------------------
  localparam int unsigned F       = FRAC_BITS;
  localparam int unsigned VW      = srv_pkg::VEC_W;
  localparam int unsigned RTW     = srv_pkg::RATIO_W;
  localparam int unsigned RFRAC   = srv_pkg::RATIO_FRAC;
  localparam int unsigned PROD_W  = 2 * VW;                     // I_k * N_k
  localparam int unsigned DOT_W   = PROD_W + 2;                 // sum of three
  localparam int unsigned CS_W    = DOT_W - F;                  // -dot >> F
  localparam int unsigned CW      = (CS_W > F + 2) ? CS_W : F + 2;
  localparam int unsigned NC_W    = VW + CW;                    // N_k * cos
  localparam int unsigned NCS_W   = NC_W - F;
  localparam int unsigned T_W     = ((NCS_W > VW) ? NCS_W : VW) + 1;
  localparam int unsigned TR_W    = T_W + RTW + 1;              // t * ratio
  localparam int unsigned P0_W    = TR_W - RFRAC;
  localparam int unsigned BW      = (P0_W > F + 2) ? P0_W : F + 2;
  localparam int unsigned PW      = F + 1;                      // in-range P_k
  localparam int unsigned SQ_W    = 2 * F;
  localparam int unsigned SUM_W   = SQ_W + 2;
  localparam int unsigned QW      = 2 * F + 1;
  localparam int unsigned RW      = F + 1;                      // root width
  localparam int unsigned NS_W    = VW + RW + 1;                // N_k * root
  localparam int unsigned NSS_W   = NS_W - F;
  localparam int unsigned D_W     = ((PW > NSS_W) ? PW : NSS_W) + 1;
  localparam int unsigned SIDE_W  = 1 + 3 * PW + 3 * VW;

  // stage map: 0..7 arithmetic, 8..F+8 root, F+9 product, F+10 result
  localparam int unsigned NSTG    = F + 11;
  localparam int unsigned LAST    = NSTG - 1;

  localparam logic signed [CW-1:0]   C_ONE    = {{(CW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [BW-1:0]   P_LIM    = {{(BW-F){1'b0}}, {F{1'b1}}};
  localparam logic signed [BW-1:0]   P_LIM_N  = -P_LIM;
  localparam logic [SUM_W-1:0]       UNIT_SUM = {2'b01, {SQ_W{1'b0}}};
  localparam logic [QW-1:0]          UNIT_Q   = {1'b1, {SQ_W{1'b0}}};
  localparam logic signed [D_W-1:0]  SAT_HI   = D_W'((2 ** (VW - 1)) - 1);
  localparam logic signed [D_W-1:0]  SAT_LO   = ~SAT_HI;
  localparam logic [1:0]             SKID_FULL = 2'd2;

  // --------------------------------------------------------------------------
  // Pipeline control: one enable, valid bits shift with the data
  // --------------------------------------------------------------------------
  logic            en;
  logic [NSTG-1:0] v_q;
  logic [1:0]      cnt_q;
  logic            wr_q;
  logic            rd_q;
  logic            push;
  logic            pop;

  // advance unless a finished item would land in a full buffer
  assign en         = (cnt_q != SKID_FULL) || !v_q[LAST];
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: component products of the dot product
  // --------------------------------------------------------------------------
  logic signed [VW-1:0]     inc_in [3];
  logic signed [VW-1:0]     nrm_in [3];
  logic signed [PROD_W-1:0] prod1_q [3];
  logic signed [VW-1:0]     inc1_q [3];
  logic signed [VW-1:0]     nrm1_q [3];
  logic [RTW-1:0]           ratio1_q;

  assign inc_in[0] = in_data_i.incident_x;
  assign inc_in[1] = in_data_i.incident_y;
  assign inc_in[2] = in_data_i.incident_z;
  assign nrm_in[0] = in_data_i.normal_x;
  assign nrm_in[1] = in_data_i.normal_y;
  assign nrm_in[2] = in_data_i.normal_z;

  // --------------------------------------------------------------------------
  // Stage 2: cosine = floor(-dot / 2^F), clamped to at most one
  // --------------------------------------------------------------------------
  logic signed [DOT_W-1:0] dot2;
  logic signed [DOT_W-1:0] neg2;
  logic signed [CS_W-1:0]  cs2;
  logic signed [CW-1:0]    cse2;
  logic signed [CW-1:0]    c2;
  logic signed [CW-1:0]    c2_q;
  logic signed [VW-1:0]    inc2_q [3];
  logic signed [VW-1:0]    nrm2_q [3];
  logic [RTW-1:0]          ratio2_q;

  always_comb begin
    dot2 = DOT_W'(prod1_q[0]) + DOT_W'(prod1_q[1]) + DOT_W'(prod1_q[2]);
    neg2 = -dot2;
    cs2  = neg2[DOT_W-1:F];
    cse2 = CW'(cs2);
    c2   = (cse2 > C_ONE) ? C_ONE : cse2;
  end

  // --------------------------------------------------------------------------
  // Stages 3 to 5: perpendicular part, (I + floor(N*c/2^F)) * ratio
  // --------------------------------------------------------------------------
  logic signed [NC_W-1:0]  nc3_q [3];
  logic signed [VW-1:0]    inc3_q [3];
  logic signed [VW-1:0]    nrm3_q [3];
  logic [RTW-1:0]          ratio3_q;

  logic signed [NCS_W-1:0] ncs4 [3];
  logic signed [T_W-1:0]   t4_q [3];
  logic signed [VW-1:0]    nrm4_q [3];
  logic [RTW-1:0]          ratio4_q;

  logic signed [RTW:0]     rat5;
  logic signed [TR_W-1:0]  tr5_q [3];
  logic signed [VW-1:0]    nrm5_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ncs4[k] = nc3_q[k][NC_W-1:F];
    end
  end

  assign rat5 = {1'b0, ratio4_q};

  // --------------------------------------------------------------------------
  // Stage 6: scale down by the ratio fraction, flag components of size >= 1
  // --------------------------------------------------------------------------
  logic signed [P0_W-1:0] p06 [3];
  logic signed [BW-1:0]   pb6 [3];
  logic signed [PW-1:0]   pn6 [3];
  logic [2:0]             big6;
  logic signed [PW-1:0]   perp6_q [3];
  logic [F-1:0]           mag6_q [3];
  logic                   big6_q;
  logic signed [VW-1:0]   nrm6_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p06[k]  = tr5_q[k][TR_W-1:RFRAC];
      pb6[k]  = BW'(p06[k]);
      big6[k] = (pb6[k] > P_LIM) || (pb6[k] < P_LIM_N);
      pn6[k]  = -pb6[k][PW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 7 and 8: squared length and the radicand 1 - |P|^2
  // --------------------------------------------------------------------------
  logic [SQ_W-1:0]        sq7_q [3];
  logic signed [PW-1:0]   perp7_q [3];
  logic                   big7_q;
  logic signed [VW-1:0]   nrm7_q [3];

  logic [SUM_W-1:0]       sum8;
  logic [QW-1:0]          q8_q;
  logic                   tir8_q;
  logic signed [PW-1:0]   perp8_q [3];
  logic signed [VW-1:0]   nrm8_q [3];

  assign sum8 = SUM_W'(sq7_q[0]) + SUM_W'(sq7_q[1]) + SUM_W'(sq7_q[2]);

  // --------------------------------------------------------------------------
  // Datapath registers of the arithmetic stages
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        prod1_q[k] <= PROD_W'(inc_in[k]) * PROD_W'(nrm_in[k]);
        inc1_q[k]  <= inc_in[k];
        nrm1_q[k]  <= nrm_in[k];

        inc2_q[k]  <= inc1_q[k];
        nrm2_q[k]  <= nrm1_q[k];

        nc3_q[k]   <= NC_W'(nrm2_q[k]) * NC_W'(c2_q);
        inc3_q[k]  <= inc2_q[k];
        nrm3_q[k]  <= nrm2_q[k];

        t4_q[k]    <= T_W'(inc3_q[k]) + T_W'(ncs4[k]);
        nrm4_q[k]  <= nrm3_q[k];

        tr5_q[k]   <= TR_W'(t4_q[k]) * TR_W'(rat5);
        nrm5_q[k]  <= nrm4_q[k];

        perp6_q[k] <= pb6[k][PW-1:0];
        mag6_q[k]  <= pb6[k][PW-1] ? pn6[k][F-1:0] : pb6[k][F-1:0];
        nrm6_q[k]  <= nrm5_q[k];

        sq7_q[k]   <= SQ_W'(mag6_q[k]) * SQ_W'(mag6_q[k]);
        perp7_q[k] <= perp6_q[k];
        nrm7_q[k]  <= nrm6_q[k];

        perp8_q[k] <= perp7_q[k];
        nrm8_q[k]  <= nrm7_q[k];
      end
      ratio1_q <= in_data_i.index_ratio;
      ratio2_q <= ratio1_q;
      c2_q     <= c2;
      ratio3_q <= ratio2_q;
      ratio4_q <= ratio3_q;
      big6_q   <= |big6;
      big7_q   <= big6_q;
      // a component of size one or more already means total reflection
      tir8_q   <= big7_q || (sum8 >= UNIT_SUM);
      q8_q     <= UNIT_Q - sum8[QW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipeline; P, N and the reflection flag ride as sideband
  // --------------------------------------------------------------------------
  logic [SIDE_W-1:0]    side8;
  logic [SIDE_W-1:0]    side_s;
  logic [RW-1:0]        root_s;
  logic                 tir_s;
  logic signed [PW-1:0] perp_s [3];
  logic signed [VW-1:0] nrm_s [3];

  assign side8 = {tir8_q, perp8_q[0], perp8_q[1], perp8_q[2],
                  nrm8_q[0], nrm8_q[1], nrm8_q[2]};
  assign {tir_s, perp_s[0], perp_s[1], perp_s[2],
          nrm_s[0], nrm_s[1], nrm_s[2]} = side_s;

  srv_isqrt #(
    .FRAC_BITS (F),
    .SIDE_W    (SIDE_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (q8_q),
    .side_i (side8),
    .root_o (root_s),
    .side_o (side_s)
  );

  // --------------------------------------------------------------------------
  // Product stage N * root, then subtract, saturate and zero on reflection
  // --------------------------------------------------------------------------
  logic signed [RW:0]      root_sg;
  logic signed [NS_W-1:0]  nsb_q [3];
  logic signed [PW-1:0]    perpb_q [3];
  logic                    tirb_q;

  logic signed [NSS_W-1:0] nss [3];
  logic signed [D_W-1:0]   dif [3];
  logic signed [VW-1:0]    sat [3];
  srv_pkg::srv_out_t       res_d;
  srv_pkg::srv_out_t       res_q;

  assign root_sg = {1'b0, root_s};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nss[k] = nsb_q[k][NS_W-1:F];
      dif[k] = D_W'(perpb_q[k]) - D_W'(nss[k]);
      if (dif[k] > SAT_HI) begin
        sat[k] = SAT_HI[VW-1:0];
      end else if (dif[k] < SAT_LO) begin
        sat[k] = SAT_LO[VW-1:0];
      end else begin
        sat[k] = dif[k][VW-1:0];
      end
    end
    res_d.out_x        = tirb_q ? '0 : sat[0];
    res_d.out_y        = tirb_q ? '0 : sat[1];
    res_d.out_z        = tirb_q ? '0 : sat[2];
    res_d.refracted_ok = !tirb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nsb_q[k]   <= NS_W'(nrm_s[k]) * NS_W'(root_sg);
        perpb_q[k] <= perp_s[k];
      end
      tirb_q <= tir_s;
      res_q  <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer: parts the pipeline from the output handshake
  // --------------------------------------------------------------------------
  srv_pkg::srv_out_t skid_q [2];

  assign push        = en && v_q[LAST];
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = skid_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      skid_q[wr_q] <= res_q;
    end
  end

`ifndef SYNTHESIS
  // a reflected ray always leaves with a zero direction
  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.refracted_ok) |->
      (out_data_o.out_x == '0 && out_data_o.out_y == '0 && out_data_o.out_z == '0))
    else $error("reflected result with nonzero direction");

  // hold every stage valid bit while the pipeline is stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline valid bits moved during a stall");

  // an accepted input shows up as a valid first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted input lost at pipeline entry");

  // output buffer never overfills
  a_buf_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SKID_FULL)
    else $error("output buffer overflow");
`endif

endmodule

FILE: src/srv_isqrt.sv
// ----------------------------------------------------------------------------
// srv_isqrt: pipelined integer square root
// Floor square root of a 2*FRAC_BITS+1 bit radicand, one root bit per stage,
// FRAC_BITS+1 stages. A sideband word travels alongside the radicand.
// ----------------------------------------------------------------------------
module srv_isqrt #(
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned SIDE_W    = 1
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*FRAC_BITS:0]   rad_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [FRAC_BITS:0]     root_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int unsigned QW   = 2 * FRAC_BITS + 1;
  localparam int unsigned NSTG = FRAC_BITS + 1;

  logic [QW-1:0]     rem_q  [NSTG];
  logic [QW-1:0]     res_q  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];

  for (genvar j = 0; j < NSTG; j++) begin : g_stage
    localparam logic [QW-1:0] BIT = QW'(1) << (2 * (FRAC_BITS - j));

    logic [QW-1:0]     rem_in;
    logic [QW-1:0]     res_in;
    logic [SIDE_W-1:0] side_in;
    logic [QW:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign res_in  = res_q[j-1];
      assign side_in = side_q[j-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, BIT};
    assign ge    = {1'b0, rem_in} >= trial;

    // subtract the trial value when it fits, shift the partial root
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ge) begin
          rem_q[j] <= rem_in - trial[QW-1:0];
          res_q[j] <= (res_in >> 1) + BIT;
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in >> 1;
        end
        side_q[j] <= side_in;
      end
    end
  end

  assign root_o = res_q[NSTG-1][FRAC_BITS:0];
  assign side_o = side_q[NSTG-1];

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for snell_refraction_vector
// Streams incident/normal/ratio rays into the block and compares every
// refracted direction against an in-bench fixed-point predictor. Covers edge
// values, boundary and saturation cases, random unit rays, raw bit patterns,
// back-to-back traffic and drain-and-refill bursts, with random source gaps
// and sink stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC       = 14;                          // vector fraction bits
  localparam int ONE        = 1 << FRAC;                   // 1.0 in Q2.14
  localparam int RATIO_ONE  = 1 << srv_pkg::RATIO_FRAC;    // 1.0 in Q4.12
  localparam int LATENCY    = FRAC + 11;                   // stages from input to result register
  localparam int IDLE_LIMIT = 1000;                        // cycles with no transfer

  localparam longint PERP_MAX = 64'sd2147483647;
  localparam longint OUT_MAX  = 64'sd32767;
  localparam longint OUT_MIN  = -64'sd32768;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  srv_pkg::srv_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  srv_pkg::srv_out_t out_data_o;

  // Idling knobs, flipped by the tests.
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  // Expected directions, oldest first, plus run statistics.
  srv_pkg::srv_out_t pending_dirs[$];
  int                rays_sent    = 0;
  int                dirs_checked = 0;
  int                tir_seen     = 0;
  int                mismatches   = 0;

  snell_refraction_vector #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Floor of the square root, one result bit at a time from the top.
  function automatic longint unsigned root_floor(longint unsigned val);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= val) root = trial;
    end
    return root;
  endfunction

  // Refracted direction for one ray. All shifts are arithmetic, so every
  // rescale rounds toward minus infinity.
  function automatic srv_pkg::srv_out_t refract_ray(srv_pkg::srv_in_t ray);
    longint            inc [3];
    longint            nrm [3];
    longint            perp[3];
    longint            ratio;
    longint            dot;
    longint            cos_t;
    longint            t;
    longint unsigned   len2;
    longint unsigned   slack;
    longint            s;
    longint            dir [3];
    srv_pkg::srv_out_t res;
    inc[0] = $signed(ray.incident_x);
    inc[1] = $signed(ray.incident_y);
    inc[2] = $signed(ray.incident_z);
    nrm[0] = $signed(ray.normal_x);
    nrm[1] = $signed(ray.normal_y);
    nrm[2] = $signed(ray.normal_z);
    ratio  = longint'(ray.index_ratio);
    dot    = inc[0] * nrm[0] + inc[1] * nrm[1] + inc[2] * nrm[2];
    // Cosine is clamped from above only; back-facing rays go negative.
    cos_t  = (-dot) >>> FRAC;
    if (cos_t > ONE) cos_t = ONE;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      t = inc[k] + ((nrm[k] * cos_t) >>> FRAC);
      t = (t * ratio) >>> srv_pkg::RATIO_FRAC;
      if (t > PERP_MAX) t = PERP_MAX;
      if (t < -PERP_MAX) t = -PERP_MAX;
      perp[k] = t;
      len2 += longint'(t * t);
    end
    res = '0;
    // No parallel part left: total internal reflection, zero direction.
    if (len2 >= (64'd1 << (2 * FRAC))) return res;
    slack = (64'd1 << (2 * FRAC)) - len2;
    s     = longint'(root_floor(slack));
    for (int k = 0; k < 3; k++) begin
      t = perp[k] - ((nrm[k] * s) >>> FRAC);
      if (t > OUT_MAX) t = OUT_MAX;
      if (t < OUT_MIN) t = OUT_MIN;
      dir[k] = t;
    end
    res.out_x        = 16'(dir[0]);
    res.out_y        = 16'(dir[1]);
    res.out_z        = 16'(dir[2]);
    res.refracted_ok = 1'b1;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: check the output transfer first, then log the input transfer.
  // Both handshakes are sampled at the rising edge, before any update lands.
  // --------------------------------------------------------------------------

  function automatic bit field_ok(string name, logic signed [15:0] want_v,
                                  logic signed [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    srv_pkg::srv_out_t want;
    bit                good;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_dirs.size() == 0) begin
          $display("%0t: unexpected result, expected none actual (%0d %0d %0d ok=%0b)",
                   $time, out_data_o.out_x, out_data_o.out_y, out_data_o.out_z,
                   out_data_o.refracted_ok);
          mismatches++;
        end else begin
          want = pending_dirs.pop_front();
          good = 1'b1;
          good &= field_ok("out_x", want.out_x, out_data_o.out_x);
          good &= field_ok("out_y", want.out_y, out_data_o.out_y);
          good &= field_ok("out_z", want.out_z, out_data_o.out_z);
          good &= field_ok("refracted_ok", want.refracted_ok, out_data_o.refracted_ok);
          if (!good) mismatches++;
          if (!want.refracted_ok) tir_seen++;
          dirs_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_dirs.push_back(refract_ray(in_data_i));
        rays_sent++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idling: pause lengths are mostly short, a few long.
  // --------------------------------------------------------------------------

  function automatic int pause_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Output side: random stalls while enabled, ready held high otherwise.
  initial begin : sink
    int stall_left;
    stall_left = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        stall_left = pause_len() - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Abort when neither channel has moved for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  // Offer one ray and hold it until the transfer. Called at a rising edge;
  // returns at the edge of the transfer, leaving valid high.
  task automatic send_ray(srv_pkg::srv_in_t ray);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) < 30) gap = pause_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ray;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold until every expected direction has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_dirs.size() != 0);
  endtask

  function automatic srv_pkg::srv_in_t make_ray(int ix, int iy, int iz, int nx, int ny, int nz,
                                                int ratio);
    srv_pkg::srv_in_t ray;
    ray.incident_x  = 16'(ix);
    ray.incident_y  = 16'(iy);
    ray.incident_z  = 16'(iz);
    ray.normal_x    = 16'(nx);
    ray.normal_y    = 16'(ny);
    ray.normal_z    = 16'(nz);
    ray.index_ratio = 16'(ratio);
    return ray;
  endfunction

  // Random direction of roughly unit length in Q2.14.
  task automatic rand_unit(output int ux, output int uy, output int uz);
    int  ax, ay, az;
    real mag;
    ax  = $urandom_range(0, 2 * ONE) - ONE;
    ay  = $urandom_range(0, 2 * ONE) - ONE;
    az  = $urandom_range(0, 2 * ONE) - ONE;
    mag = $sqrt(real'(ax * ax + ay * ay + az * az));
    if (mag < 1.0) begin
      ux = 0;
      uy = 0;
      uz = ONE;
    end else begin
      ux = int'(real'(ax) * ONE / mag);
      uy = int'(real'(ay) * ONE / mag);
      uz = int'(real'(az) * ONE / mag);
    end
  endtask

  // Ratios cluster around common glass/water/air values, with some spread.
  function automatic int pick_ratio();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(RATIO_ONE / 2, 2 * RATIO_ONE);
    if (pick < 80) return RATIO_ONE;
    if (pick < 90) return $urandom_range(0, 65535);
    return $urandom_range(0, RATIO_ONE / 2);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Edge values and the named special cases.
  task automatic test_directed();
    // Head-on ray leaves straight through for any ratio.
    send_ray(make_ray(0, -ONE, 0, 0, ONE, 0, RATIO_ONE));
    send_ray(make_ray(0, 0, -ONE, 0, 0, ONE, 6144));
    send_ray(make_ray(0, -ONE, 0, 0, ONE, 0, 65535));
    // 45 degrees: unchanged, bent toward the normal, total internal reflection.
    send_ray(make_ray(11585, -11585, 0, 0, ONE, 0, RATIO_ONE));
    send_ray(make_ray(11585, -11585, 0, 0, ONE, 0, 2731));
    send_ray(make_ray(11585, -11585, 0, 0, ONE, 0, 6144));
    send_ray(make_ray(11585, -11585, 0, 0, ONE, 0, 0));
    send_ray(make_ray(11585, -11585, 0, 0, ONE, 0, 65535));
    // Grazing ray: perpendicular part of exactly unit length reflects.
    send_ray(make_ray(ONE, 0, 0, 0, ONE, 0, RATIO_ONE));
    // Zero normal: q hits exactly zero at ratio 1.0, just positive below it.
    send_ray(make_ray(ONE, 0, 0, 0, 0, 0, RATIO_ONE));
    send_ray(make_ray(ONE, 0, 0, 0, 0, 0, RATIO_ONE - 1));
    // Non-unit incident: cosine clamps to 1.0 from above.
    send_ray(make_ray(0, -2 * ONE, 0, 0, ONE, 0, RATIO_ONE));
    // Back-facing ray: negative cosine is passed through unclamped.
    send_ray(make_ray(11585, 11585, 0, 0, ONE, 0, RATIO_ONE));
    // All-zero ray and field extremes.
    send_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
    send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767, 65535));
    send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 0));
    send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
    send_ray(make_ray(1, 1, 1, 0, 0, 0, 65535));
    // Output clipping at the top and bottom of the 16 bit range.
    send_ray(make_ray(0, 0, 0, -32768, 0, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, -32768, -32768, RATIO_ONE));
    send_ray(make_ray(-4000, 8000, 0, 32767, 16384, 0, 64));
    wait_drained();
  endtask

  // Random unit rays; most face the surface. A few are off unit length.
  // Drain now and then so the sender also sees an empty pipeline.
  task automatic test_unit_rays(int count, int drain_every);
    int ix, iy, iz, nx, ny, nz;
    int pick;
    for (int n = 0; n < count; n++) begin
      rand_unit(nx, ny, nz);
      rand_unit(ix, iy, iz);
      if ($urandom_range(0, 99) < 85 && ix * nx + iy * ny + iz * nz > 0) begin
        ix = -ix;
        iy = -iy;
        iz = -iz;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        ix = ix * 2;
        iy = iy * 2;
        iz = iz * 2;
      end else if (pick < 10) begin
        ix = ix / 4;
        iy = iy / 4;
        iz = iz / 4;
      end else if (pick < 15) begin
        ix += $urandom_range(0, 64) - 32;
        nz += $urandom_range(0, 64) - 32;
      end
      send_ray(make_ray(ix, iy, iz, nx, ny, nz, pick_ratio()));
      if (drain_every > 0 && n % drain_every == drain_every - 1) wait_drained();
    end
    wait_drained();
  endtask

  // Full random bit patterns on every field.
  task automatic test_raw_fields(int count);
    logic [127:0]     raw;
    srv_pkg::srv_in_t ray;
    for (int n = 0; n < count; n++) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      ray = raw[$bits(srv_pkg::srv_in_t)-1:0];
      send_ray(ray);
    end
    wait_drained();
  endtask

  // No gaps, no stalls: one transfer per cycle in both directions.
  task automatic test_back_to_back(int count);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    test_unit_rays(count, 0);
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Fill with a burst, hold the source until the pipeline is empty, repeat.
  task automatic test_drain_bursts(int bursts, int burst_len);
    for (int b = 0; b < bursts; b++) begin
      gaps_on = (b % 2 == 0);
      test_unit_rays(burst_len, 0);
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_unit_rays(700, 175);
    test_back_to_back(300);
    test_raw_fields(300);
    test_drain_bursts(4, 50);
    test_unit_rays(100, 0);

    // Wait until everything is back, then idle on for any strays.
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Sent %0d rays and checked %0d directions under random gaps and stalls:",
             rays_sent, dirs_checked);
    $display("  %0d refracted, %0d total internal reflection, %0d mismatched.",
             dirs_checked - tir_seen, tir_seen, mismatches);
    if (mismatches == 0 && pending_dirs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/srv_pkg.sv
src/srv_isqrt.sv
src/snell_refraction_vector.sv
sim/tb.sv
